[sv/ubrt_pkg.sv]
package ubrt_pkg;

    // Ring depths. Each ring holds at most DEPTH - 1 bytes.
    localparam int RX_DEPTH = 64;
    localparam int TX_DEPTH = 64;

    localparam int RX_PTR_W = $clog2(RX_DEPTH);
    localparam int TX_PTR_W = $clog2(TX_DEPTH);
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

    localparam int LEVEL_W = 6;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 40;
    localparam int OPCODE_W = 3;

    localparam logic [OPCODE_W-1:0] OP_LINE_RX = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_HOST_RD = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_HOST_WR = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_TX_READY = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic commit;
    } ubrt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
    } ubrt_status_t;

endpackage

[sv/uart_buffered_rx_tx_fifo.sv]
// Buffered receive and transmit byte rings for a serial port. Each request on the
// slave stream carries an opcode in s_tuser (line receive, host read, host write,
// transmitter ready, clear both) and produces exactly one result on the master
// stream, in request order. Each ring holds up to depth minus one bytes, so a
// line-receive request into a full ring is dropped and a host write into a full
// transmit ring is rejected rather than waited on. A request is accepted in the
// idle state while the ring stores present their registered read data at the
// current read pointers; the execute state then updates the pointers and loads
// the result register once the output is free or being read. A new request is
// accepted while a result waits there, but not while one is still executing. The
// parity check enable register is written with cfg_we and should only change
// while no request is in flight.
module uart_buffered_rx_tx_fifo
    import ubrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Request stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // From bit 0 up: data_byte[7:0], frame_error, overrun_error, parity_error, zero pad.
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // opcode[2:0].
    input  logic [OPCODE_W-1:0]   s_tuser,
    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // From bit 0 up: read_valid, read_data[7:0], send_valid, send_data[7:0],
    // write_accepted, rx_dropped, send_started, send_idle, rx_level[5:0],
    // tx_level[5:0], zero pad.
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Parity check enable register.
    input  logic                  cfg_we,
    input  logic                  cfg_wdata
);

    ubrt_cmd_t    cmd;
    ubrt_status_t status;

    // The controller sequences accept and commit; it sees only handshakes and status.
    ubrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the ring stores, the pointers and the result register.
    ubrt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule

[sv/ubrt_ctrl.sv]
module ubrt_ctrl
    import ubrt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         m_tready,
    input  ubrt_status_t status,
    output ubrt_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.accept = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.commit = (state_reg == ST_EXEC) && (!status.out_valid || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/ubrt_datapath.sv]
module ubrt_datapath
    import ubrt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ubrt_cmd_t             cmd,
    output ubrt_status_t          status,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [OPCODE_W-1:0]   s_tuser,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata
);

    localparam logic [RX_PTR_W-1:0] RX_LAST = RX_PTR_W'(RX_DEPTH - 1);
    localparam logic [TX_PTR_W-1:0] TX_LAST = TX_PTR_W'(TX_DEPTH - 1);

    logic [7:0] rx_mem [RX_DEPTH];
    logic [7:0] tx_mem [TX_DEPTH];

    logic [RX_PTR_W-1:0] rx_wp_reg, rx_wp_next, rx_rp_reg, rx_rp_next;
    logic [TX_PTR_W-1:0] tx_wp_reg, tx_wp_next, tx_rp_reg, tx_rp_next;
    logic [7:0]          rx_rdata_reg, tx_rdata_reg;
    logic                parity_en_reg;

    logic [OPCODE_W-1:0] op_reg;
    logic [7:0]          byte_reg;
    logic                fe_reg, ov_reg, pe_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [RX_PTR_W-1:0] rx_wp_inc, rx_rp_inc;
    logic [TX_PTR_W-1:0] tx_wp_inc, tx_rp_inc;
    logic                rx_empty, rx_full, tx_empty, tx_full;
    logic                rx_push, tx_push;
    logic [RX_CNT_W-1:0] rx_level;
    logic [TX_CNT_W-1:0] tx_level;

    logic       read_valid, send_valid, write_accepted, rx_dropped;
    logic       send_started, send_idle;
    logic [7:0] read_data, send_data;

    assign rx_wp_inc = (rx_wp_reg == RX_LAST) ? '0 : rx_wp_reg + 1'b1;
    assign rx_rp_inc = (rx_rp_reg == RX_LAST) ? '0 : rx_rp_reg + 1'b1;
    assign tx_wp_inc = (tx_wp_reg == TX_LAST) ? '0 : tx_wp_reg + 1'b1;
    assign tx_rp_inc = (tx_rp_reg == TX_LAST) ? '0 : tx_rp_reg + 1'b1;

    assign rx_empty = (rx_wp_reg == rx_rp_reg);
    assign rx_full  = (rx_wp_inc == rx_rp_reg);
    assign tx_empty = (tx_wp_reg == tx_rp_reg);
    assign tx_full  = (tx_wp_inc == tx_rp_reg);

    always_comb
    begin
        rx_wp_next     = rx_wp_reg;
        rx_rp_next     = rx_rp_reg;
        tx_wp_next     = tx_wp_reg;
        tx_rp_next     = tx_rp_reg;
        rx_push        = 1'b0;
        tx_push        = 1'b0;
        read_valid     = 1'b0;
        read_data      = 8'd0;
        send_valid     = 1'b0;
        send_data      = 8'd0;
        write_accepted = 1'b0;
        rx_dropped     = 1'b0;
        send_started   = 1'b0;
        send_idle      = 1'b0;
        unique case (op_reg)
            OP_LINE_RX:
            begin
                if (fe_reg || ov_reg || (parity_en_reg && pe_reg) || rx_full)
                begin
                    rx_dropped = 1'b1;
                end
                else
                begin
                    rx_push    = 1'b1;
                    rx_wp_next = rx_wp_inc;
                end
            end
            OP_HOST_RD:
            begin
                if (!rx_empty)
                begin
                    read_valid = 1'b1;
                    read_data  = rx_rdata_reg;
                    rx_rp_next = rx_rp_inc;
                end
            end
            OP_HOST_WR:
            begin
                if (!tx_full)
                begin
                    write_accepted = 1'b1;
                    send_started   = tx_empty;
                    tx_push        = 1'b1;
                    tx_wp_next     = tx_wp_inc;
                end
            end
            OP_TX_READY:
            begin
                if (tx_empty)
                begin
                    send_idle = 1'b1;
                end
                else
                begin
                    send_valid = 1'b1;
                    send_data  = tx_rdata_reg;
                    tx_rp_next = tx_rp_inc;
                end
            end
            OP_CLEAR:
            begin
                rx_wp_next = '0;
                rx_rp_next = '0;
                tx_wp_next = '0;
                tx_rp_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (rx_wp_next >= rx_rp_next)
        begin
            rx_level = RX_CNT_W'(rx_wp_next) - RX_CNT_W'(rx_rp_next);
        end
        else
        begin
            rx_level = RX_CNT_W'(rx_wp_next) + RX_CNT_W'(RX_DEPTH) - RX_CNT_W'(rx_rp_next);
        end
        if (tx_wp_next >= tx_rp_next)
        begin
            tx_level = TX_CNT_W'(tx_wp_next) - TX_CNT_W'(tx_rp_next);
        end
        else
        begin
            tx_level = TX_CNT_W'(tx_wp_next) + TX_CNT_W'(TX_DEPTH) - TX_CNT_W'(tx_rp_next);
        end
    end

    // Byte stores; read data is registered every cycle at the current read pointers.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && rx_push)
        begin
            rx_mem[rx_wp_reg] <= byte_reg;
        end
        rx_rdata_reg <= rx_mem[rx_rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && tx_push)
        begin
            tx_mem[tx_wp_reg] <= byte_reg;
        end
        tx_rdata_reg <= tx_mem[tx_rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= s_tuser;
            byte_reg <= s_tdata[7:0];
            fe_reg   <= s_tdata[8];
            ov_reg   <= s_tdata[9];
            pe_reg   <= s_tdata[10];
        end
        if (cmd.commit)
        begin
            out_data_reg <= {6'd0,
                             LEVEL_W'(tx_level), LEVEL_W'(rx_level),
                             send_idle, send_started, rx_dropped, write_accepted,
                             send_data, send_valid, read_data, read_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wp_reg     <= '0;
            rx_rp_reg     <= '0;
            tx_wp_reg     <= '0;
            tx_rp_reg     <= '0;
            parity_en_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                parity_en_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                rx_wp_reg     <= rx_wp_next;
                rx_rp_reg     <= rx_rp_next;
                tx_wp_reg     <= tx_wp_next;
                tx_rp_reg     <= tx_rp_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_valid = out_valid_reg;
    assign m_tvalid         = out_valid_reg;
    assign m_tdata          = out_data_reg;

endmodule

[sv/ubrt_checker.sv]
module ubrt_checker
    import ubrt_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Data bytes are zero unless their valid flag is set.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] || (m_tdata[8:1] == 8'd0))
                  && (m_tdata[9] || (m_tdata[17:10] == 8'd0)))
        else $error("data byte without valid flag");

    // A result reports at most one outcome.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({m_tdata[0], m_tdata[9], m_tdata[18], m_tdata[19], m_tdata[21]}))
        else $error("more than one outcome flag");

    // A send start only comes with an accepted write, which leaves one byte queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[20] |-> m_tdata[18] && (m_tdata[33:28] == 6'd1))
        else $error("send start without accepted write into empty ring");

endmodule

bind uart_buffered_rx_tx_fifo ubrt_checker u_ubrt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/tb.sv]
`timescale 1ns / 1ps

// Testbench for the buffered serial-port byte rings. Requests go in on the slave
// stream and every request yields one response on the master stream, in order.
// A predictor keeps its own copy of both rings, their pointers and the parity
// check enable. It works out the response of each request when the request is
// accepted, and the monitor compares each response with the oldest prediction.
module tb;
    import ubrt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD_CYCLES = 400;

    // Opcodes the block does not define. They must change no state.
    localparam logic [OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LAST = 3'd7;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                parity_error;
        logic                overrun_error;
        logic                frame_error;
        logic [7:0]          data_byte;
    } request_t;

    // Packed from the top bit down, so bit 0 is read_valid as on m_tdata.
    typedef struct packed {
        logic [LEVEL_W-1:0] tx_level;
        logic [LEVEL_W-1:0] rx_level;
        logic               send_idle;
        logic               send_started;
        logic               rx_dropped;
        logic               write_accepted;
        logic [7:0]         send_data;
        logic               send_valid;
        logic [7:0]         read_data;
        logic               read_valid;
    } response_t;

    localparam int RESP_W = $bits(response_t);

    // Traffic shapes for the random part.
    typedef enum int {
        FILL_RX,
        FILL_TX,
        DRAIN_BOTH,
        BALANCED,
        NOISE
    } traffic_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [OPCODE_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic                  cfg_wdata;

    // Predicted state of the block.
    logic [7:0]          rx_bytes [RX_DEPTH];
    logic [7:0]          tx_bytes [TX_DEPTH];
    logic [RX_PTR_W-1:0] rx_wr;
    logic [RX_PTR_W-1:0] rx_rd;
    logic [TX_PTR_W-1:0] tx_wr;
    logic [TX_PTR_W-1:0] tx_rd;
    logic                parity_drop_en;

    request_t  pending_requests [$];
    response_t expected_responses [$];
    request_t  offered_request;
    bit        request_taken;

    bit idle_enabled;
    int src_gap;
    int src_quiet;
    int sink_gap;
    int sink_quiet;
    int sink_hold;
    int mismatches;
    int cycle_count;

    uart_buffered_rx_tx_fifo u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Applies one request to the predicted rings and returns its response.
    function automatic response_t ring_response(request_t req);
        response_t           resp;
        logic [RX_PTR_W-1:0] rx_next;
        logic [TX_PTR_W-1:0] tx_next;
        resp = '0;
        rx_next = rx_wr + 1'b1;
        tx_next = tx_wr + 1'b1;
        case (req.op)
            OP_LINE_RX:
            begin
                if (req.frame_error || req.overrun_error ||
                    (parity_drop_en && req.parity_error) || rx_next == rx_rd)
                begin
                    resp.rx_dropped = 1'b1;
                end
                else
                begin
                    rx_bytes[rx_wr] = req.data_byte;
                    rx_wr = rx_next;
                end
            end
            OP_HOST_RD:
            begin
                if (rx_wr != rx_rd)
                begin
                    resp.read_valid = 1'b1;
                    resp.read_data = rx_bytes[rx_rd];
                    rx_rd = rx_rd + 1'b1;
                end
            end
            OP_HOST_WR:
            begin
                if (tx_next != tx_rd)
                begin
                    resp.write_accepted = 1'b1;
                    resp.send_started = (tx_wr == tx_rd);
                    tx_bytes[tx_wr] = req.data_byte;
                    tx_wr = tx_next;
                end
            end
            OP_TX_READY:
            begin
                if (tx_wr == tx_rd)
                begin
                    resp.send_idle = 1'b1;
                end
                else
                begin
                    resp.send_valid = 1'b1;
                    resp.send_data = tx_bytes[tx_rd];
                    tx_rd = tx_rd + 1'b1;
                end
            end
            OP_CLEAR:
            begin
                // Pointers return to zero; the stored bytes stay where they are.
                rx_wr = '0;
                rx_rd = '0;
                tx_wr = '0;
                tx_rd = '0;
            end
            default:
            begin
            end
        endcase
        // Pointer widths match the depths, so the difference is the level.
        resp.rx_level = LEVEL_W'(rx_wr - rx_rd);
        resp.tx_level = LEVEL_W'(tx_wr - tx_rd);
        return resp;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    // Request side: a new request is put out at the falling edge once the
    // previous one was taken. Idle gaps come at random, with quiet
    // stretches in between.
    always @(negedge clk)
    begin : drive_requests
        logic [IN_DATA_W-1:0] word;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !request_taken)
        begin
            // Hold the offered request until the block takes it.
        end
        else if (src_gap > 0)
        begin
            src_gap--;
            s_tvalid <= 1'b0;
        end
        else if (pending_requests.size() > 0)
        begin
            offered_request = pending_requests.pop_front();
            word = '0;
            word[10:0] = {offered_request.parity_error, offered_request.overrun_error,
                          offered_request.frame_error, offered_request.data_byte};
            s_tdata <= word;
            s_tuser <= offered_request.op;
            s_tvalid <= 1'b1;
            if (idle_enabled)
            begin
                if (src_quiet > 0)
                    src_quiet--;
                else if ($urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 14);
                else if ($urandom_range(0, 63) == 0)
                    src_quiet = $urandom_range(20, 80);
            end
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
        request_taken = 1'b0;
    end

    // Each accepted request is predicted at the edge that takes it.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_responses.push_back(ring_response(offered_request));
            request_taken = 1'b1;
        end
    end

    // Response side: ready drops in random bursts, and once for a long hold
    // that lets the block fill up and push back on the request stream.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (sink_hold > 0)
        begin
            sink_hold--;
            m_tready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (idle_enabled)
            begin
                if (sink_quiet > 0)
                    sink_quiet--;
                else if ($urandom_range(0, 7) == 0)
                    sink_gap = $urandom_range(1, 14);
                else if ($urandom_range(0, 63) == 0)
                    sink_quiet = $urandom_range(20, 80);
            end
        end
    end

    always @(posedge clk)
    begin : check_responses
        response_t got;
        response_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[RESP_W-1:0];
            if (expected_responses.size() == 0)
            begin
                mismatches++;
                $error("response with no request outstanding: m_tdata %h", m_tdata);
            end
            else
            begin
                want = expected_responses.pop_front();
                check_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
                check_field("read_data", 32'(want.read_data), 32'(got.read_data));
                check_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
                check_field("send_data", 32'(want.send_data), 32'(got.send_data));
                check_field("write_accepted", 32'(want.write_accepted),
                            32'(got.write_accepted));
                check_field("rx_dropped", 32'(want.rx_dropped), 32'(got.rx_dropped));
                check_field("send_started", 32'(want.send_started),
                            32'(got.send_started));
                check_field("send_idle", 32'(want.send_idle), 32'(got.send_idle));
                check_field("rx_level", 32'(want.rx_level), 32'(got.rx_level));
                check_field("tx_level", 32'(want.tx_level), 32'(got.tx_level));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_request(logic [OPCODE_W-1:0] op, logic [7:0] data_byte,
                                 logic frame_error, logic overrun_error,
                                 logic parity_error);
        request_t req;
        req.op = op;
        req.data_byte = data_byte;
        req.frame_error = frame_error;
        req.overrun_error = overrun_error;
        req.parity_error = parity_error;
        pending_requests.push_back(req);
    endtask

    // Waits until every request has been taken and answered, then a little more.
    task automatic wait_until_settled();
        while (pending_requests.size() != 0 || s_tvalid || expected_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_parity_enable(logic value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        parity_drop_en = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic request_t random_request(traffic_t shape);
        request_t req;
        req.data_byte = 8'($urandom);
        // Mostly clean line bytes so that the receive ring actually fills.
        req.frame_error = ($urandom_range(0, 9) == 0);
        req.overrun_error = ($urandom_range(0, 9) == 0);
        req.parity_error = ($urandom_range(0, 3) == 0);
        case (shape)
            FILL_RX:
                req.op = ($urandom_range(0, 9) == 0) ? OP_HOST_RD : OP_LINE_RX;
            FILL_TX:
                req.op = ($urandom_range(0, 9) == 0) ? OP_TX_READY : OP_HOST_WR;
            DRAIN_BOTH:
                req.op = ($urandom_range(0, 1) == 0) ? OP_HOST_RD : OP_TX_READY;
            BALANCED:
                req.op = OPCODE_W'($urandom_range(OP_LINE_RX, OP_TX_READY));
            default:
            begin
                req.op = OPCODE_W'($urandom);
                req.frame_error = 1'($urandom);
                req.overrun_error = 1'($urandom);
                req.parity_error = 1'($urandom);
            end
        endcase
        return req;
    endfunction

    // Random traffic in segments of one shape each; a segment can be long
    // enough to run a ring from empty to full or back.
    task automatic queue_random(int count);
        traffic_t shape;
        int       seg_len;
        int       queued;
        queued = 0;
        while (queued < count)
        begin
            shape = traffic_t'($urandom_range(FILL_RX, NOISE));
            seg_len = $urandom_range(1, 70);
            repeat (seg_len)
            begin
                pending_requests.push_back(random_request(shape));
                queued++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LINE_RX;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        idle_enabled = 1'b1;
        request_taken = 1'b0;
        src_gap = 0;
        src_quiet = 0;
        sink_gap = 0;
        sink_quiet = 0;
        sink_hold = 0;
        mismatches = 0;
        cycle_count = 0;
        rx_wr = '0;
        rx_rd = '0;
        tx_wr = '0;
        tx_rd = '0;
        parity_drop_en = 1'b0;
        foreach (rx_bytes[i])
            rx_bytes[i] = '0;
        foreach (tx_bytes[i])
            tx_bytes[i] = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with parity checking off: empty rings, data extremes,
        // each line error alone, a write into an empty transmit ring, draining
        // past empty, the undefined opcodes and a clear.
        write_parity_enable(1'b0);
        queue_request(OP_HOST_RD, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_request(OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_request(OP_LINE_RX, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_request(OP_LINE_RX, 8'hFF, 1'b0, 1'b0, 1'b0);
        queue_request(OP_LINE_RX, 8'h5A, 1'b1, 1'b0, 1'b0);
        queue_request(OP_LINE_RX, 8'hA5, 1'b0, 1'b1, 1'b0);
        queue_request(OP_LINE_RX, 8'h3C, 1'b0, 1'b0, 1'b1);
        queue_request(OP_HOST_WR, 8'hFF, 1'b0, 1'b0, 1'b0);
        queue_request(OP_HOST_WR, 8'h00, 1'b1, 1'b1, 1'b1);
        repeat (3) queue_request(OP_TX_READY, 8'h00, 1'b0, 1'b0, 1'b0);
        repeat (4) queue_request(OP_HOST_RD, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_request(OP_UNUSED_FIRST, 8'hFF, 1'b1, 1'b1, 1'b1);
        queue_request(OP_UNUSED_FIRST + 3'd1, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_request(OP_UNUSED_LAST, 8'h81, 1'b0, 1'b0, 1'b0);
        queue_request(OP_LINE_RX, 8'h81, 1'b0, 1'b0, 1'b0);
        queue_request(OP_HOST_WR, 8'h7E, 1'b0, 1'b0, 1'b0);
        queue_request(OP_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0);
        queue_request(OP_HOST_RD, 8'h00, 1'b0, 1'b0, 1'b0);
        wait_until_settled();

        // With parity checking on, a parity error alone now drops the byte.
        write_parity_enable(1'b1);
        queue_request(OP_LINE_RX, 8'hC3, 1'b0, 1'b0, 1'b1);
        queue_request(OP_LINE_RX, 8'h99, 1'b1, 1'b1, 1'b1);
        queue_request(OP_LINE_RX, 8'h42, 1'b0, 1'b0, 1'b0);
        queue_request(OP_HOST_RD, 8'h00, 1'b0, 1'b0, 1'b0);
        wait_until_settled();

        queue_random(300);
        wait_until_settled();

        // The response side holds off for a long stretch while requests keep
        // coming, so the block has to stall its request stream.
        write_parity_enable(1'b0);
        queue_random(300);
        sink_hold = LONG_HOLD_CYCLES;
        wait_until_settled();

        write_parity_enable(1'b1);
        queue_random(300);
        wait_until_settled();

        write_parity_enable(1'b0);
        queue_random(300);
        wait_until_settled();

        // Last stretch at full rate on both sides; leftover gaps are dropped too.
        idle_enabled = 1'b0;
        src_gap = 0;
        sink_gap = 0;
        write_parity_enable(1'b1);
        queue_random(130);
        wait_until_settled();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
